// ===== rtl/core/cscan_pkg.sv =====
// Shared types and constants of the C-SCAN disk request scheduler.
package cscan_pkg;

   localparam int TOTAL_BITS = 22;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 22'h3FFFFF;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_TRACK = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAD_POSITION = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWEEP_DIRECTION = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      AFT_SCAN,
      AFT_JUMP,
      AFT_DONE
   } after_type;

   typedef enum logic [1:0] {
      TO_SCAN,
      TO_END,
      TO_PEND
   } to_sel_type;

   typedef struct packed {
      logic       load_en;
      logic       scan_start;
      logic       scan_run;
      logic       phase_b;
      logic       key_start_a;
      logic       key_start_b;
      logic       key_load_best;
      logic       pos_load_head;
      logic       total_clear;
      logic       load_move;
      to_sel_type to_sel;
      logic       move_final;
      logic       pend_load_jump;
      logic       pend_load_best;
      logic       count_clear;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic rsp_taken;
   } status_type;

endpackage

// ===== rtl/core/cscan_regs.sv =====
// Configuration registers of the C-SCAN scheduler.
module cscan_regs #(
   parameter int TRACK_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cscan_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [TRACK_BITS-1:0]               csr_data,
   output logic [TRACK_BITS-1:0]               max_track,
   output logic [TRACK_BITS-1:0]               head_position,
   output logic                                sweep_direction
);
   import cscan_pkg::*;

   logic [TRACK_BITS-1:0] max_track_ff, max_track_in;
   logic [TRACK_BITS-1:0] head_ff, head_in;
   logic                  dir_ff, dir_in;

   assign csr_ready = 1'b1;

   always_comb begin
      max_track_in = max_track_ff;
      head_in      = head_ff;
      dir_in       = dir_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_TRACK:       max_track_in = csr_data;
            CSR_HEAD_POSITION:   head_in      = csr_data;
            CSR_SWEEP_DIRECTION: dir_in       = csr_data[0];
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_track_ff <= TRACK_BITS'(199);
         head_ff      <= '0;
         dir_ff       <= 1'b1;
      end else begin
         max_track_ff <= max_track_in;
         head_ff      <= head_in;
         dir_ff       <= dir_in;
      end
   end

   assign max_track       = max_track_ff;
   assign head_position   = head_ff;
   assign sweep_direction = dir_ff;

endmodule

// ===== rtl/core/cscan_ctrl.sv =====
// Sequencing state machine of the C-SCAN scheduler.
module cscan_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_stall,
   input  cscan_pkg::status_type  sts,
   output cscan_pkg::cmd_type     cmd
);
   import cscan_pkg::*;

   state_type state_ff, state_in;
   after_type after_ff, after_in;
   logic      phase_b_ff, phase_b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         after_ff   <= AFT_SCAN;
         phase_b_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         after_ff   <= after_in;
         phase_b_ff <= phase_b_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      after_in    = after_ff;
      phase_b_in  = phase_b_ff;
      cmd         = '0;
      cmd.to_sel  = TO_SCAN;
      cmd.phase_b = phase_b_ff;
      req_stall   = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall   = 1'b0;
            cmd.load_en = 1'b1;
            if (req_valid && req_last) begin
               cmd.key_start_a   = 1'b1;
               cmd.pos_load_head = 1'b1;
               cmd.total_clear   = 1'b1;
               cmd.scan_start    = 1'b1;
               phase_b_in        = 1'b0;
               state_in          = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               cmd.load_move = 1'b1;
               state_in      = ST_EMIT;
               if (!phase_b_ff) begin
                  if (sts.found) begin
                     cmd.to_sel        = TO_SCAN;
                     cmd.key_load_best = 1'b1;
                     after_in          = AFT_SCAN;
                  end else begin
                     cmd.to_sel = TO_END;
                     after_in   = AFT_JUMP;
                  end
               end else begin
                  cmd.to_sel = TO_PEND;
                  if (sts.found) begin
                     cmd.pend_load_best = 1'b1;
                     cmd.key_load_best  = 1'b1;
                     after_in           = AFT_SCAN;
                  end else begin
                     cmd.move_final = 1'b1;
                     after_in       = AFT_DONE;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (sts.rsp_taken) begin
               case (after_ff)
                  AFT_SCAN: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  AFT_JUMP: begin
                     cmd.key_start_b    = 1'b1;
                     cmd.pend_load_jump = 1'b1;
                     cmd.scan_start     = 1'b1;
                     phase_b_in         = 1'b1;
                     state_in           = ST_SCAN;
                  end
                  AFT_DONE: begin
                     cmd.count_clear = 1'b1;
                     state_in        = ST_LOAD;
                  end
                  default: state_in = ST_LOAD;
               endcase
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule

// ===== rtl/core/cscan_dp.sv =====
// Request store, selection scan and move arithmetic of the C-SCAN scheduler.
module cscan_dp #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cscan_pkg::cmd_type                 cmd,
   output cscan_pkg::status_type              sts,
   input  logic [TRACK_BITS-1:0]              max_track,
   input  logic [TRACK_BITS-1:0]              head_position,
   input  logic                               sweep_direction,
   input  logic                               req_valid,
   input  logic [TRACK_BITS-1:0]              req_track,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [TRACK_BITS-1:0]              rsp_from_track,
   output logic [TRACK_BITS-1:0]              rsp_to_track,
   output logic [TRACK_BITS-1:0]              rsp_distance,
   output logic [cscan_pkg::TOTAL_BITS-1:0]   rsp_total_seek,
   output logic                               rsp_final_move
);
   import cscan_pkg::*;

   localparam int IDX_BITS = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);
   localparam int SUM_BITS = ((TRACK_BITS > TOTAL_BITS) ? TRACK_BITS : TOTAL_BITS) + 1;
   localparam logic [CNT_BITS-1:0] COUNT_FULL = CNT_BITS'(MAX_REQUESTS);

   logic [TRACK_BITS-1:0] mem [MAX_REQUESTS];

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   issue_ff, issue_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic [TRACK_BITS-1:0] rd_data_ff;
   logic                  found_ff, found_in;
   logic [TRACK_BITS-1:0] best_v_ff, best_v_in;
   logic [IDX_BITS-1:0]   best_i_ff, best_i_in;
   logic [TRACK_BITS-1:0] key_v_ff, key_v_in;
   logic [IDX_BITS-1:0]   key_i_ff, key_i_in;
   logic                  key_sent_ff, key_sent_in;
   logic [TRACK_BITS-1:0] pos_ff, pos_in;
   logic [TRACK_BITS-1:0] pend_ff, pend_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  out_valid_ff, out_valid_in;
   logic [TRACK_BITS-1:0] out_from_ff, out_from_in;
   logic [TRACK_BITS-1:0] out_to_ff, out_to_in;
   logic [TRACK_BITS-1:0] out_dist_ff, out_dist_in;
   logic [TOTAL_BITS-1:0] out_total_ff, out_total_in;
   logic                  out_final_ff, out_final_in;

   logic                  mem_we;
   logic                  rd_en;
   logic [TRACK_BITS-1:0] head;
   logic [TRACK_BITS-1:0] end_track;
   logic [TRACK_BITS-1:0] jump_track;
   logic                  order_ok;
   logic                  qualifies;
   logic                  better;
   logic [TRACK_BITS-1:0] to_track;
   logic [TRACK_BITS-1:0] move_dist;
   logic [SUM_BITS-1:0]   sum;
   logic                  rsp_taken;

   assign head       = (head_position > max_track) ? max_track : head_position;
   assign end_track  = sweep_direction ? max_track : '0;
   assign jump_track = sweep_direction ? '0 : max_track;

   assign mem_we = cmd.load_en && req_valid && (req_track <= max_track)
                   && (count_ff < COUNT_FULL);
   assign rd_en  = cmd.scan_run && (issue_ff < count_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_BITS-1:0]] <= req_track;
      end
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[IDX_BITS-1:0]];
      end
   end

   always_comb begin
      if (sweep_direction) begin
         if (key_sent_ff) begin
            order_ok = rd_data_ff >= key_v_ff;
         end else begin
            order_ok = (rd_data_ff > key_v_ff)
                       || ((rd_data_ff == key_v_ff) && (rd_idx_ff > key_i_ff));
         end
      end else begin
         if (key_sent_ff) begin
            order_ok = rd_data_ff <= key_v_ff;
         end else begin
            order_ok = (rd_data_ff < key_v_ff)
                       || ((rd_data_ff == key_v_ff) && (rd_idx_ff < key_i_ff));
         end
      end
   end

   assign qualifies = rd_valid_ff && order_ok && (rd_data_ff <= max_track)
                      && (!cmd.phase_b
                          || (sweep_direction ? (rd_data_ff < head) : (rd_data_ff > head)));
   assign better    = !found_ff
                      || (sweep_direction ? (rd_data_ff < best_v_ff) : (rd_data_ff >= best_v_ff));

   always_comb begin
      case (cmd.to_sel)
         TO_SCAN: to_track = best_v_ff;
         TO_END:  to_track = end_track;
         TO_PEND: to_track = pend_ff;
         default: to_track = best_v_ff;
      endcase
   end

   assign move_dist = (pos_ff > to_track) ? (pos_ff - to_track) : (to_track - pos_ff);
   assign sum       = SUM_BITS'(total_ff) + SUM_BITS'(move_dist);

   assign rsp_taken = out_valid_ff && !rsp_stall;

   always_comb begin
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      best_v_in    = best_v_ff;
      best_i_in    = best_i_ff;
      key_v_in     = key_v_ff;
      key_i_in     = key_i_ff;
      key_sent_in  = key_sent_ff;
      pos_in       = pos_ff;
      pend_in      = pend_ff;
      total_in     = total_ff;
      out_valid_in = out_valid_ff && !rsp_taken;
      out_from_in  = out_from_ff;
      out_to_in    = out_to_ff;
      out_dist_in  = out_dist_ff;
      out_total_in = out_total_ff;
      out_final_in = out_final_ff;

      if (mem_we) begin
         count_in = count_ff + CNT_BITS'(1);
      end
      if (cmd.count_clear) begin
         count_in = '0;
      end

      if (cmd.scan_start) begin
         issue_in = '0;
         found_in = 1'b0;
      end else begin
         if (rd_en) begin
            rd_valid_in = 1'b1;
            rd_idx_in   = issue_ff[IDX_BITS-1:0];
            issue_in    = issue_ff + CNT_BITS'(1);
         end
         if (qualifies && better) begin
            found_in  = 1'b1;
            best_v_in = rd_data_ff;
            best_i_in = rd_idx_ff;
         end
      end

      if (cmd.key_start_a) begin
         key_v_in    = head;
         key_i_in    = '0;
         key_sent_in = 1'b1;
      end else if (cmd.key_start_b) begin
         key_v_in    = jump_track;
         key_i_in    = '0;
         key_sent_in = 1'b1;
      end else if (cmd.key_load_best) begin
         key_v_in    = best_v_ff;
         key_i_in    = best_i_ff;
         key_sent_in = 1'b0;
      end

      if (cmd.pend_load_jump) begin
         pend_in = jump_track;
      end else if (cmd.pend_load_best) begin
         pend_in = best_v_ff;
      end

      if (cmd.pos_load_head) begin
         pos_in = head;
      end
      if (cmd.total_clear) begin
         total_in = '0;
      end

      if (cmd.load_move) begin
         out_valid_in = 1'b1;
         out_from_in  = pos_ff;
         out_to_in    = to_track;
         out_dist_in  = move_dist;
         out_final_in = cmd.move_final;
         if (sum > SUM_BITS'(TOTAL_MAX)) begin
            out_total_in = TOTAL_MAX;
         end else begin
            out_total_in = sum[TOTAL_BITS-1:0];
         end
         total_in = out_total_in;
         pos_in   = to_track;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         key_sent_ff  <= 1'b1;
         pos_ff       <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         key_sent_ff  <= key_sent_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      best_v_ff    <= best_v_in;
      best_i_ff    <= best_i_in;
      key_v_ff     <= key_v_in;
      key_i_ff     <= key_i_in;
      pend_ff      <= pend_in;
      out_from_ff  <= out_from_in;
      out_to_ff    <= out_to_in;
      out_dist_ff  <= out_dist_in;
      out_total_ff <= out_total_in;
      out_final_ff <= out_final_in;
   end

   assign sts.scan_done = (issue_ff == count_ff) && !rd_valid_ff;
   assign sts.found     = found_ff;
   assign sts.rsp_taken = rsp_taken;

   assign rsp_valid      = out_valid_ff;
   assign rsp_from_track = out_from_ff;
   assign rsp_to_track   = out_to_ff;
   assign rsp_distance   = out_dist_ff;
   assign rsp_total_seek = out_total_ff;
   assign rsp_final_move = out_final_ff;

endmodule

// ===== rtl/core/cscan_disk_request_scheduler.sv =====
// Top level of the C-SCAN disk request scheduler.
//
// Track requests arrive on the req_ channel, one transfer per cycle while the
// block collects a batch. Requests above max_track, and requests beyond
// MAX_REQUESTS stored entries, are dropped. The transfer with req_last high
// closes the batch; req_stall then stays high until every head move of the
// batch has been delivered.
// Each head move leaves on the rsp_ channel as one transfer. Finding the next
// track is a scan of the n stored requests through the store's single read
// port. The next scan starts only after the receiver has taken the current
// move. While rsp_stall is high the move stays on the outputs and the block
// waits.
// Configuration writes on the csr_ channel are always taken; the user must make
// them only while the block collects requests, as the block does not enforce it.
// Reset restores max_track 199, head_position 0 and sweep_direction 1, and
// empties the batch; no clearing pass is needed.
module cscan_disk_request_scheduler #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [TRACK_BITS-1:0]                req_track,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [TRACK_BITS-1:0]                rsp_from_track,
   output logic [TRACK_BITS-1:0]                rsp_to_track,
   output logic [TRACK_BITS-1:0]                rsp_distance,
   output logic [cscan_pkg::TOTAL_BITS-1:0]     rsp_total_seek,
   output logic                                 rsp_final_move,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cscan_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [TRACK_BITS-1:0]                csr_data
);
   import cscan_pkg::*;

   cmd_type               cmd;
   status_type            sts;
   logic [TRACK_BITS-1:0] max_track;
   logic [TRACK_BITS-1:0] head_position;
   logic                  sweep_direction;

   cscan_regs #(
      .TRACK_BITS(TRACK_BITS)
   ) u_regs (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .max_track       (max_track),
      .head_position   (head_position),
      .sweep_direction (sweep_direction)
   );

   cscan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cscan_dp #(
      .MAX_REQUESTS(MAX_REQUESTS),
      .TRACK_BITS  (TRACK_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .max_track       (max_track),
      .head_position   (head_position),
      .sweep_direction (sweep_direction),
      .req_valid       (req_valid),
      .req_track       (req_track),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_from_track  (rsp_from_track),
      .rsp_to_track    (rsp_to_track),
      .rsp_distance    (rsp_distance),
      .rsp_total_seek  (rsp_total_seek),
      .rsp_final_move  (rsp_final_move)
   );

endmodule

// ===== tb/cscan_disk_request_scheduler_tb.sv =====
// Self-checking testbench for the C-SCAN disk request scheduler.
`timescale 1ns / 1ps

module cscan_disk_request_scheduler_tb;
   import cscan_pkg::*;

   localparam int MAX_REQUESTS = 32;
   localparam int TRACK_BITS = 16;
   localparam int RANDOM_ITEMS = 350;
   localparam int CALM_ITEMS = 50;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 40;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [TRACK_BITS-1:0] from_track;
      logic [TRACK_BITS-1:0] to_track;
      logic [TRACK_BITS-1:0] distance;
      logic [TOTAL_BITS-1:0] total_seek;
      logic                  final_move;
   } move_record;

   typedef enum logic {
      ROW_REQUEST,
      ROW_WRITE
   } row_kind;

   typedef struct packed {
      row_kind                   kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [TRACK_BITS-1:0]     value;
      logic                      closes;
      logic                      typed;
      logic [TRACK_BITS-1:0]     fin_from;
      logic [TRACK_BITS-1:0]     fin_to;
      logic [TOTAL_BITS-1:0]     fin_total;
   } stim_row;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [TRACK_BITS-1:0]     req_track = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [TRACK_BITS-1:0]     rsp_from_track;
   logic [TRACK_BITS-1:0]     rsp_to_track;
   logic [TRACK_BITS-1:0]     rsp_distance;
   logic [TOTAL_BITS-1:0]     rsp_total_seek;
   logic                      rsp_final_move;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [TRACK_BITS-1:0]     csr_data = '0;

   logic [TRACK_BITS-1:0] cfg_max_track = 16'd199;
   logic [TRACK_BITS-1:0] cfg_head = '0;
   logic                  cfg_dir = 1'b1;
   logic [TRACK_BITS-1:0] batch_tracks[$];
   move_record            pending_moves[$];
   stim_row               stim_table[$];

   int failures = 0;
   int moves_checked = 0;
   int requests_sent = 0;
   int batches_closed = 0;
   int writes_done = 0;
   int random_items = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int cycle_count = 0;

   cscan_disk_request_scheduler #(
      .MAX_REQUESTS(MAX_REQUESTS),
      .TRACK_BITS(TRACK_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_track(req_track),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_from_track(rsp_from_track),
      .rsp_to_track(rsp_to_track),
      .rsp_distance(rsp_distance),
      .rsp_total_seek(rsp_total_seek),
      .rsp_final_move(rsp_final_move),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stores one request and, when it closes the batch, queues every head move of the sweep.
   function automatic void take_request(input logic [TRACK_BITS-1:0] trk, input logic closes);
      logic [TRACK_BITS-1:0] kept[$];
      logic [TRACK_BITS-1:0] order[$];
      logic [TRACK_BITS-1:0] start;
      logic [TRACK_BITS-1:0] hold;
      logic [TRACK_BITS-1:0] a;
      logic [TRACK_BITS-1:0] b;
      int i;
      int j;
      int split;
      int unsigned running;
      move_record mv;
      if (trk <= cfg_max_track && batch_tracks.size() < MAX_REQUESTS) begin
         batch_tracks.push_back(trk);
      end
      if (!closes) begin
         return;
      end
      start = (cfg_head > cfg_max_track) ? cfg_max_track : cfg_head;
      for (i = 0; i < batch_tracks.size(); i++) begin
         if (batch_tracks[i] <= cfg_max_track) begin
            kept.push_back(batch_tracks[i]);
         end
      end
      for (i = 1; i < kept.size(); i++) begin
         hold = kept[i];
         j = i;
         while (j > 0 && kept[j-1] > hold) begin
            kept[j] = kept[j-1];
            j--;
         end
         kept[j] = hold;
      end
      order.push_back(start);
      split = 0;
      if (cfg_dir) begin
         while (split < kept.size() && kept[split] < start) split++;
         for (i = split; i < kept.size(); i++) order.push_back(kept[i]);
         order.push_back(cfg_max_track);
         order.push_back('0);
         for (i = 0; i < split; i++) order.push_back(kept[i]);
      end else begin
         while (split < kept.size() && kept[split] <= start) split++;
         for (i = split; i > 0; i--) order.push_back(kept[i-1]);
         order.push_back('0);
         order.push_back(cfg_max_track);
         for (i = kept.size(); i > split; i--) order.push_back(kept[i-1]);
      end
      running = 0;
      for (i = 0; i + 1 < order.size(); i++) begin
         a = order[i];
         b = order[i+1];
         mv.from_track = a;
         mv.to_track = b;
         mv.distance = (a > b) ? a - b : b - a;
         running = running + mv.distance;
         if (running > TOTAL_MAX) begin
            running = TOTAL_MAX;
         end
         mv.total_seek = running[TOTAL_BITS-1:0];
         mv.final_move = (i + 2 == order.size());
         pending_moves.push_back(mv);
      end
      batch_tracks.delete();
      batches_closed++;
   endfunction

   function automatic logic [TRACK_BITS-1:0] pick_track();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return TRACK_BITS'($urandom_range(0, cfg_max_track));
      end else if (roll < 65) begin
         return cfg_max_track;
      end else if (roll < 72) begin
         return '0;
      end else if (roll < 80) begin
         return cfg_head;
      end
      return TRACK_BITS'($urandom);
   endfunction

   function automatic void add_request(input logic [TRACK_BITS-1:0] trk, input logic closes);
      stim_row r;
      r = '0;
      r.kind = ROW_REQUEST;
      r.value = trk;
      r.closes = closes;
      stim_table.push_back(r);
   endfunction

   function automatic void add_write(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [TRACK_BITS-1:0] val);
      stim_row r;
      r = '0;
      r.kind = ROW_WRITE;
      r.index = idx;
      r.value = val;
      stim_table.push_back(r);
   endfunction

   function automatic void add_known_close(input logic [TRACK_BITS-1:0] trk,
                                           input logic [TRACK_BITS-1:0] fin_from,
                                           input logic [TRACK_BITS-1:0] fin_to,
                                           input logic [TOTAL_BITS-1:0] fin_total);
      stim_row r;
      r = '0;
      r.kind = ROW_REQUEST;
      r.value = trk;
      r.closes = 1'b1;
      r.typed = 1'b1;
      r.fin_from = fin_from;
      r.fin_to = fin_to;
      r.fin_total = fin_total;
      stim_table.push_back(r);
   endfunction

   task automatic send_request(input logic [TRACK_BITS-1:0] trk, input logic closes);
      int gap;
      gap = 0;
      if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
         gap = $urandom_range(1, 18);
      end
      if (csr_valid) begin
         csr_valid <= 1'b0;
      end
      if (gap > 0) begin
         if (req_valid) begin
            req_valid <= 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_track <= trk;
      req_last <= closes;
      do @(posedge clock); while (req_stall);
      take_request(trk, closes);
      requests_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [TRACK_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MAX_TRACK: begin
            cfg_max_track = val;
         end
         CSR_HEAD_POSITION: begin
            cfg_head = val;
         end
         CSR_SWEEP_DIRECTION: begin
            cfg_dir = val[0];
         end
         default: begin
         end
      endcase
      writes_done++;
   endtask

   task automatic settle(input int extra);
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      if (csr_valid) begin
         csr_valid <= 1'b0;
      end
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_moves
      move_record got;
      move_record want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_from_track, rsp_to_track, rsp_distance, rsp_total_seek, rsp_final_move};
         if (pending_moves.size() == 0) begin
            if (failures < 10) begin
               $display("unexpected move %0d->%0d dist %0d total %0d final %0b",
                        got.from_track, got.to_track, got.distance, got.total_seek,
                        got.final_move);
            end
            failures++;
         end else begin
            want = pending_moves.pop_front();
            moves_checked++;
            if (got.from_track !== want.from_track || got.to_track !== want.to_track ||
                got.distance !== want.distance || got.total_seek !== want.total_seek ||
                got.final_move !== want.final_move) begin
               if (failures < 10) begin
                  $display("move mismatch: expected %0d->%0d dist %0d total %0d final %0b",
                           want.from_track, want.to_track, want.distance, want.total_seek,
                           want.final_move);
                  $display("                    got %0d->%0d dist %0d total %0d final %0b",
                           got.from_track, got.to_track, got.distance, got.total_seek,
                           got.final_move);
               end
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d moves outstanding", cycle_count,
                  pending_moves.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin : run_stimulus
      stim_row row;
      row_kind prev_kind;
      move_record fin;
      logic [TRACK_BITS-1:0] trk;
      int batch_len;
      int k;
      int pct_steps[3];
      pct_steps = '{0, 10, 40};

      add_known_close(16'hFFFF, 16'd199, 16'd0, 22'd398);
      add_request(16'd0, 1'b0);
      add_request(16'd199, 1'b0);
      add_request(16'd200, 1'b0);
      add_request(16'd50, 1'b1);
      add_write(CSR_MAX_TRACK, 16'hFFFF);
      add_write(CSR_HEAD_POSITION, 16'hFFFF);
      add_write(CSR_SWEEP_DIRECTION, 16'd0);
      add_request(16'd0, 1'b0);
      add_request(16'hFFFF, 1'b0);
      add_request(16'h8000, 1'b1);
      add_write(CSR_MAX_TRACK, 16'd1000);
      add_known_close(16'hFFFF, 16'd0, 16'd1000, 22'd2000);
      add_request(16'd900, 1'b0);
      add_request(16'd10, 1'b0);
      add_write(CSR_MAX_TRACK, 16'd100);
      add_request(16'd20, 1'b1);
      add_write(CSR_MAX_TRACK, 16'd0);
      add_write(CSR_HEAD_POSITION, 16'd0);
      add_write(CSR_SWEEP_DIRECTION, 16'd1);
      add_known_close(16'd0, 16'd0, 16'd0, 22'd0);
      add_write(CSR_MAX_TRACK, 16'd199);
      add_write(CSR_HEAD_POSITION, 16'd53);
      add_request(16'd98, 1'b0);
      add_request(16'd183, 1'b0);
      add_request(16'd37, 1'b0);
      add_request(16'd122, 1'b0);
      add_request(16'd14, 1'b0);
      add_request(16'd124, 1'b0);
      add_request(16'd65, 1'b0);
      add_known_close(16'd67, 16'd14, 16'd37, 22'd382);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 10;
      stall_pct = 10;
      prev_kind = ROW_WRITE;
      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.kind == ROW_WRITE) begin
            if (prev_kind == ROW_REQUEST) begin
               settle(SETTLE_CYCLES);
            end
            write_csr(row.index, row.value);
         end else begin
            send_request(row.value, row.closes);
            if (row.typed) begin
               fin = pending_moves.pop_back();
               fin.from_track = row.fin_from;
               fin.to_track = row.fin_to;
               fin.distance = (row.fin_from > row.fin_to) ? row.fin_from - row.fin_to :
                                                             row.fin_to - row.fin_from;
               fin.total_seek = row.fin_total;
               fin.final_move = 1'b1;
               pending_moves.push_back(fin);
            end
         end
         prev_kind = row.kind;
      end
      settle(SETTLE_CYCLES);

      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS - CALM_ITEMS) begin
            send_gap_pct = 0;
            stall_pct = 0;
         end else begin
            send_gap_pct = pct_steps[$urandom_range(0, 2)];
            stall_pct = pct_steps[$urandom_range(0, 2)];
         end
         if ($urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 4))
               0: write_csr(CSR_MAX_TRACK, 16'd0);
               1: write_csr(CSR_MAX_TRACK, 16'hFFFF);
               2: write_csr(CSR_MAX_TRACK, TRACK_BITS'($urandom_range(1, 255)));
               default: write_csr(CSR_MAX_TRACK, TRACK_BITS'($urandom));
            endcase
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 3))
                  0: write_csr(CSR_HEAD_POSITION, 16'd0);
                  1: write_csr(CSR_HEAD_POSITION, 16'hFFFF);
                  2: write_csr(CSR_HEAD_POSITION,
                               TRACK_BITS'($urandom_range(0, cfg_max_track)));
                  default: write_csr(CSR_HEAD_POSITION, TRACK_BITS'($urandom));
               endcase
            end
            if ($urandom_range(0, 1) == 1) begin
               write_csr(CSR_SWEEP_DIRECTION, TRACK_BITS'($urandom));
            end
            if ($urandom_range(0, 9) == 0) begin
               write_csr(CSR_UNUSED, TRACK_BITS'($urandom));
            end
         end
         batch_len = ($urandom_range(0, 99) < 12) ? $urandom_range(28, 40) :
                                                     $urandom_range(0, 8);
         for (k = 0; k <= batch_len; k++) begin
            if (k > 0 && k < batch_len && $urandom_range(0, 99) < 6) begin
               // Lower the limit while requests are already stored.
               settle(SETTLE_CYCLES);
               write_csr(CSR_MAX_TRACK, TRACK_BITS'($urandom_range(0, cfg_max_track)));
            end
            trk = pick_track();
            random_items++;
            send_request(trk, k == batch_len);
         end
         settle(SETTLE_CYCLES);
      end

      settle(TAIL_CYCLES);
      $display("covered %0d requests in %0d batches with %0d register writes",
               requests_sent, batches_closed, writes_done);
      $display("checked %0d head moves, %0d failures", moves_checked, failures);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cscan_pkg.sv
rtl/core/cscan_regs.sv
rtl/core/cscan_ctrl.sv
rtl/core/cscan_dp.sv
rtl/core/cscan_disk_request_scheduler.sv
tb/cscan_disk_request_scheduler_tb.sv
